### hdl/mini_printf_value_formatter_assert.svh
// Assertion macros for the formatter's top-level checks.
`ifndef MINI_PRINTF_VALUE_FORMATTER_ASSERT_SVH
`define MINI_PRINTF_VALUE_FORMATTER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define MPF_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication, checked out of reset.
`define MPF_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/mpf_pkg.sv
// Shared types and constants of the format expander.
package mpf_pkg;

    localparam int CH_W  = 8;
    localparam int VAL_W = 16;
    localparam int ACC_W = 36;
    localparam int DIG_W = 4;
    localparam int CNT_W = 3;
    localparam int KIND_W = 2;
    localparam int QDEPTH = 2;
    localparam int QA_W = $clog2(QDEPTH);
    localparam int QC_W = $clog2(QDEPTH + 1);

    // Command kinds carried from front to back
    localparam logic [KIND_W-1:0] KIND_LIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEC = 2'd2;

    // ASCII codes
    localparam logic [CH_W-1:0] CH_PCT   = 8'h25;
    localparam logic [CH_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [CH_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CH_W-1:0] CH_D_LO  = 8'h64;
    localparam logic [CH_W-1:0] CH_I_LO  = 8'h69;
    localparam logic [CH_W-1:0] CH_C_LO  = 8'h63;
    localparam logic [CH_W-1:0] CH_C_UP  = 8'h43;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_A_UP  = 8'h41;

    // ceil(2^32 / 10000): value * this is value/10000 in 3.32 fixed point
    localparam logic [18:0] DEC_RECIP = 19'd429497;

    localparam logic [CNT_W-1:0] LEN_LIT = 3'd1;
    localparam logic [CNT_W-1:0] LEN_HEX = 3'd4;
    localparam logic [CNT_W-1:0] LEN_DEC = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ACC_W-1:0]  acc;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### hdl/mpf_if.sv
// Valid/ready channel interfaces for format characters and output characters.
interface mpf_in_if import mpf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  fmt_char;
    logic [VAL_W-1:0] print_value;
    logic             string_end;

    modport source (output valid, fmt_char, print_value, string_end, input ready);
    modport sink   (input valid, fmt_char, print_value, string_end, output ready);
endinterface

interface mpf_out_if import mpf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_char;
    logic            run_last;

    modport source (output valid, out_char, run_last, input ready);
    modport sink   (input valid, out_char, run_last, output ready);
endinterface

### hdl/mpf_front.sv
// Front end: accept format beats, track the pending percent, build commands.
module mpf_front import mpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mpf_in_if.sink     fmt,
    input  q_stat_t    q_stat,
    output logic       push,
    output cmd_t       cmd,
    output logic       pending
);

    logic              pending_reg;
    logic              pending_next;
    logic              accept;
    logic              has_cmd;
    logic [CH_W-1:0]   lit_char;
    logic [34:0]       dec_prod;

    assign fmt.ready = !q_stat.full;
    assign accept    = fmt.valid && fmt.ready;
    assign push      = accept && has_cmd;
    assign pending   = pending_reg;

    assign dec_prod = 35'(fmt.print_value * DEC_RECIP);

    always_comb
    begin
        has_cmd      = 1'b0;
        cmd.kind     = KIND_LIT;
        lit_char     = fmt.fmt_char;
        pending_next = pending_reg;
        if (pending_reg)
        begin
            pending_next = 1'b0;
            case (fmt.fmt_char)
                CH_X_LO, CH_X_UP:
                begin
                    has_cmd  = 1'b1;
                    cmd.kind = KIND_HEX;
                end
                CH_D_LO, CH_I_LO:
                begin
                    has_cmd  = 1'b1;
                    cmd.kind = KIND_DEC;
                end
                CH_C_LO, CH_C_UP:
                begin
                    has_cmd  = 1'b1;
                    lit_char = fmt.print_value[CH_W-1:0];
                end
                default:
                begin
                    has_cmd = 1'b0;
                end
            endcase
        end
        else if (fmt.fmt_char == CH_PCT)
        begin
            pending_next = 1'b1;
        end
        else
        begin
            has_cmd = 1'b1;
        end
        if (fmt.string_end)
        begin
            pending_next = 1'b0;
        end

        case (cmd.kind)
            KIND_HEX: cmd.acc = {fmt.print_value, 20'b0};
            KIND_DEC: cmd.acc = {1'b0, dec_prod};
            default:  cmd.acc = {lit_char, 28'b0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

### hdl/mpf_fifo.sv
// Short command queue between the front end and the character generator.
module mpf_fifo import mpf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    wdata,
    input  logic    pop,
    output cmd_t    rdata,
    output q_stat_t stat
);

    cmd_t            mem_reg [QDEPTH];
    logic [QA_W-1:0] wr_ptr_reg;
    logic [QA_W-1:0] rd_ptr_reg;
    logic [QC_W-1:0] count_reg;
    logic [QC_W-1:0] count_next;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QC_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### hdl/mpf_back.sv
// Back end: expand one command into characters, one beat per cycle while tx is ready.
module mpf_back import mpf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_stat_t q_stat,
    input  cmd_t    q_rdata,
    output logic    pop,
    mpf_out_if.source tx
);

    logic              cur_valid_reg;
    logic [KIND_W-1:0] cur_kind_reg;
    logic [ACC_W-1:0]  cur_acc_reg;
    logic [CNT_W-1:0]  cur_cnt_reg;
    logic              out_valid_reg;
    logic [CH_W-1:0]   out_char_reg;
    logic              out_last_reg;

    logic              slot_free;
    logic              emit;
    logic              done;
    logic [DIG_W-1:0]  digit;
    logic [CH_W-1:0]   char_next;
    logic [ACC_W-1:0]  acc_low;
    logic [ACC_W-1:0]  acc_next;
    logic [CNT_W-1:0]  len_load;

    assign slot_free = !out_valid_reg || tx.ready;
    assign emit      = cur_valid_reg && slot_free;
    assign done      = emit && (cur_cnt_reg == LEN_LIT);
    assign pop       = !q_stat.empty && (!cur_valid_reg || done);

    assign digit   = cur_acc_reg[ACC_W-1 -: DIG_W];
    assign acc_low = {{DIG_W{1'b0}}, cur_acc_reg[ACC_W-DIG_W-1:0]};

    always_comb
    begin
        case (cur_kind_reg)
            KIND_HEX:
            begin
                // nibble to upper-case hex digit
                if (digit < DIG_W'(10))
                    char_next = CH_ZERO + CH_W'(digit);
                else
                    char_next = CH_A_UP + CH_W'(digit) - CH_W'(10);
                acc_next = cur_acc_reg << DIG_W;
            end
            KIND_DEC:
            begin
                // integer part is the digit, fraction times ten gives the next
                char_next = CH_ZERO + CH_W'(digit);
                acc_next  = (acc_low << 3) + (acc_low << 1);
            end
            default:
            begin
                char_next = cur_acc_reg[ACC_W-1 -: CH_W];
                acc_next  = cur_acc_reg;
            end
        endcase

        case (q_rdata.kind)
            KIND_HEX: len_load = LEN_HEX;
            KIND_DEC: len_load = LEN_DEC;
            default:  len_load = LEN_LIT;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_kind_reg <= q_rdata.kind;
            cur_acc_reg  <= q_rdata.acc;
            cur_cnt_reg  <= len_load;
        end
        else if (emit)
        begin
            cur_acc_reg <= acc_next;
            cur_cnt_reg <= cur_cnt_reg - 1'b1;
        end
        if (emit)
        begin
            out_char_reg <= char_next;
            out_last_reg <= done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                cur_valid_reg <= 1'b1;
            else if (done)
                cur_valid_reg <= 1'b0;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (tx.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign tx.valid    = out_valid_reg;
    assign tx.out_char = out_char_reg;
    assign tx.run_last = out_last_reg;

endmodule

### hdl/mini_printf_value_formatter.sv
// Top level of the format-string expander for one 16-bit value.
//
// The block takes format-string characters on fmt, one beat each, and sends
// the expanded text on tx, one character per beat; run_last marks the final
// character caused by an input beat. A plain character passes through, a
// '%' arms the conversion of the next character: x/X gives four upper-case
// hex digits, d/i five decimal digits with leading zeros, c/C the low byte
// of print_value, anything else nothing. string_end drops a pending '%'.
// Rate: the character generator drives one output beat per cycle unless tx
// stalls it, so an input beat holds the back end for each character it causes;
// plain text and a c conversion each cause one; a '%' or unknown conversion
// costs no back-end time and the front end takes a new beat every cycle while
// the two-entry command queue has room. The front end multiplies the value
// by a reciprocal of 10000 once; each decimal digit then comes from a times-ten
// shift-add on the fraction, and each hex digit from a nibble shift.
// From an input beat to its first output beat the path passes the queue
// entry, the character generator load and the output register.
module mini_printf_value_formatter import mpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mpf_in_if.sink    fmt,
    mpf_out_if.source tx
);

`include "mini_printf_value_formatter_assert.svh"

    logic    q_push;
    logic    q_pop;
    cmd_t    q_wdata;
    cmd_t    q_rdata;
    q_stat_t q_stat;
    logic    pending;
    logic    pct_take;

    // Accepted percent that is not the last character of its string
    assign pct_take = fmt.valid && fmt.ready && (fmt.fmt_char == CH_PCT) && !fmt.string_end;

    // Decode beats into commands; hold the pending percent across beats
    mpf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .fmt     (fmt),
        .q_stat  (q_stat),
        .push    (q_push),
        .cmd     (q_wdata),
        .pending (pending)
    );

    // Decouple decode from character generation
    mpf_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    // Expand commands into output beats
    mpf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .q_rdata (q_rdata),
        .pop     (q_pop),
        .tx      (tx)
    );

    `MPF_IMPLY(a_push_room, q_push, !q_stat.full, "command pushed into a full queue")
    `MPF_IMPLY(a_pop_data, q_pop, !q_stat.empty, "command popped from an empty queue")
    `MPF_IMPLY(a_pending_src, $rose(pending), $past(pct_take), "pending set without a percent")
    `MPF_ALWAYS(a_queue_bounds, !(q_stat.full && q_stat.empty), "queue both full and empty")

endmodule

### bench/tb_top.sv
// Self-checking bench for the format-string expander: directed and random beats, idle phases.
module tb_top import mpf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;

    // One format beat and one output character beat
    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [VAL_W-1:0] value;
        logic             last;
    } fmt_beat_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } tx_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mpf_in_if  fmt_ch ();
    mpf_out_if tx_ch ();

    mini_printf_value_formatter dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fmt   (fmt_ch),
        .tx    (tx_ch)
    );

    // Beats waiting for the driver, and characters the expander owes us
    fmt_beat_t fmt_pending_q[$];
    tx_beat_t  tx_expect_q[$];

    // Shadow of the one-bit "percent seen" state
    logic pct_armed = 1'b0;

    int  fmt_queued = 0;
    int  fmt_beats = 0;
    int  mismatch_cnt = 0;
    int  cycle_cnt = 0;
    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    int  hold_req = 0;
    bit  hold_on = 1'b0;
    bit  fmt_took = 1'b0;
    bit  drv_offer;
    fmt_beat_t drv_next;
    tx_beat_t  tx_want;

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drive every input to a known value before the first edge
    initial
    begin
        fmt_ch.valid       = 1'b0;
        fmt_ch.fmt_char    = '0;
        fmt_ch.print_value = '0;
        fmt_ch.string_end  = 1'b0;
        tx_ch.ready        = 1'b0;
    end

    // Expand one accepted format beat into the characters it must produce,
    // and queue them in order. The final character carries run_last.
    function automatic void predict_expansion(fmt_beat_t b);
        tx_beat_t    chars[$];
        tx_beat_t    c;
        logic [3:0]  nib;
        int unsigned rem;
        int unsigned div;
        int unsigned digit;
        c.last = 1'b0;
        if (pct_armed)
        begin
            // The beat after a percent picks the conversion; the flag drops either way
            pct_armed = 1'b0;
            case (b.ch)
                CH_X_LO, CH_X_UP:
                begin
                    for (int k = 3; k >= 0; k--)
                    begin
                        nib  = b.value[k*4 +: 4];
                        c.ch = (nib < 4'd10) ? 8'(CH_ZERO + nib) : 8'(CH_A_UP + nib - 4'd10);
                        chars.push_back(c);
                    end
                end
                CH_D_LO, CH_I_LO:
                begin
                    rem = b.value;
                    div = 10000;
                    while (div != 0)
                    begin
                        digit = rem / div;
                        rem   = rem % div;
                        c.ch  = 8'(CH_ZERO + digit);
                        chars.push_back(c);
                        div   = div / 10;
                    end
                end
                CH_C_LO, CH_C_UP:
                begin
                    c.ch = b.value[7:0];
                    chars.push_back(c);
                end
                default:
                begin
                    // unknown conversion, a second percent among them: emit nothing
                end
            endcase
        end
        else if (b.ch == CH_PCT)
        begin
            pct_armed = 1'b1;
        end
        else
        begin
            c.ch = b.ch;
            chars.push_back(c);
        end
        // End of string drops a percent left hanging
        if (b.last)
        begin
            pct_armed = 1'b0;
        end
        if (chars.size() > 0)
        begin
            chars[chars.size()-1].last = 1'b1;
        end
        foreach (chars[i])
        begin
            tx_expect_q.push_back(chars[i]);
        end
    endfunction

    function automatic void flag_mismatch(string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endfunction

    // Monitor: sample both channels at the rising edge.
    // Predict first, so a beat's characters are queued before any check.
    always @(posedge clk)
    begin
        cycle_cnt++;
        fmt_took = rst_n && fmt_ch.valid && fmt_ch.ready;
        if (fmt_took)
        begin
            predict_expansion('{ch: fmt_ch.fmt_char, value: fmt_ch.print_value,
                                last: fmt_ch.string_end});
            fmt_beats++;
        end
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (tx_expect_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected char %h run_last %b",
                                        tx_ch.out_char, tx_ch.run_last));
            end
            else
            begin
                tx_want = tx_expect_q.pop_front();
                if (tx_want.ch !== tx_ch.out_char)
                begin
                    flag_mismatch($sformatf("out_char expected %h got %h",
                                            tx_want.ch, tx_ch.out_char));
                end
                if (tx_want.last !== tx_ch.run_last)
                begin
                    flag_mismatch($sformatf("run_last expected %b got %b (char %h)",
                                            tx_want.last, tx_ch.run_last, tx_want.ch));
                end
            end
        end
    end

    // Watchdog: give up after a generous number of cycles
    always @(posedge clk)
    begin
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Format driver: hold the beat until taken, then maybe idle, then offer
    // the next one. valid gets exactly one assignment per falling edge.
    always @(negedge clk)
    begin
        drv_offer = fmt_ch.valid && !fmt_took;
        if (rst_n && !drv_offer && fmt_pending_q.size() > 0 &&
            $urandom_range(0, 99) >= src_idle_pct)
        begin
            drv_next = fmt_pending_q.pop_front();
            fmt_ch.fmt_char    <= drv_next.ch;
            fmt_ch.print_value <= drv_next.value;
            fmt_ch.string_end  <= drv_next.last;
            drv_offer = 1'b1;
        end
        fmt_ch.valid <= drv_offer;
    end

    // Output sink: stall at random, and stall throughout a long hold-off
    always @(negedge clk)
    begin
        tx_ch.ready <= rst_n && !hold_on && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Long receiver hold-off, timed here so the sender keeps pushing meanwhile
    always @(hold_req)
    begin
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    task automatic queue_beat(logic [CH_W-1:0] ch, logic [VAL_W-1:0] value, logic last);
        fmt_beat_t b;
        b.ch    = ch;
        b.value = value;
        b.last  = last;
        fmt_pending_q.push_back(b);
        fmt_queued++;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return VAL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_conversion();
        case ($urandom_range(0, 7))
            0:       return CH_X_LO;
            1:       return CH_X_UP;
            2:       return CH_D_LO;
            3:       return CH_I_LO;
            4:       return CH_C_LO;
            5:       return CH_C_UP;
            6:       return CH_PCT;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed strings (plain text and conversions, closed by
    // string_end), with some loose noise beats mixed in
    task automatic queue_random_run(int n_beats);
        fmt_beat_t str[$];
        fmt_beat_t b;
        int        tokens;
        int        done;
        done = 0;
        while (done < n_beats)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                str.delete();
                tokens = $urandom_range(1, 6);
                repeat (tokens)
                begin
                    b.value = pick_value();
                    b.last  = 1'b0;
                    if ($urandom_range(0, 9) < 6)
                    begin
                        b.ch = CH_PCT;
                        str.push_back(b);
                        b.ch = pick_conversion();
                    end
                    else
                    begin
                        b.ch = CH_W'($urandom_range(1, 255));
                    end
                    str.push_back(b);
                end
                str[str.size()-1].last = 1'b1;
                foreach (str[i])
                begin
                    queue_beat(str[i].ch, str[i].value, str[i].last);
                end
                done += str.size();
            end
            else
            begin
                queue_beat(CH_W'($urandom_range(0, 255)), pick_value(),
                           1'($urandom_range(0, 1)));
                done++;
            end
        end
    endtask

    // Wait until every queued beat is taken and every owed character has come
    task automatic drain();
        while (fmt_beats != fmt_queued || tx_expect_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_idling(int src_pct, int sink_pct);
        @(posedge clk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    initial
    begin
        // Hold reset, then release it on a falling edge
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed: field extremes, every conversion, each corner of the percent flag
        @(posedge clk);
        queue_beat(CH_A_UP, 16'h0000, 1'b0);     // plain pass-through
        queue_beat(8'h01, 16'hFFFF, 1'b0);       // lowest nonzero character
        queue_beat(8'hFF, 16'h0000, 1'b0);       // highest character
        queue_beat(8'h00, 16'h1234, 1'b0);       // zero byte passes through
        queue_beat(CH_PCT, 16'h0000, 1'b0);
        queue_beat(CH_X_LO, 16'hFFFF, 1'b0);     // hex, all ones
        queue_beat(CH_PCT, 16'h0000, 1'b0);
        queue_beat(CH_X_UP, 16'hA5C3, 1'b0);     // hex, upper-case selector
        queue_beat(CH_PCT, 16'h0000, 1'b0);
        queue_beat(CH_D_LO, 16'hFFFF, 1'b0);     // decimal, 65535
        queue_beat(CH_PCT, 16'hFFFF, 1'b0);
        queue_beat(CH_I_LO, 16'h0000, 1'b0);     // decimal, all zeros
        queue_beat(CH_PCT, 16'h0000, 1'b0);
        queue_beat(CH_C_LO, 16'h5A41, 1'b0);     // low byte
        queue_beat(CH_PCT, 16'h0000, 1'b0);
        queue_beat(CH_C_UP, 16'hFF00, 1'b0);     // zero low byte still emitted
        queue_beat(CH_PCT, 16'h0000, 1'b0);
        queue_beat(CH_PCT, 16'h0000, 1'b0);      // second percent: nothing, flag drops
        queue_beat(CH_PCT, 16'h0000, 1'b0);
        queue_beat(8'h71, 16'h00FF, 1'b0);       // unknown conversion
        queue_beat(CH_PCT, 16'h0000, 1'b0);
        queue_beat(8'h00, 16'h4321, 1'b0);       // zero byte after percent: nothing
        queue_beat(CH_PCT, 16'h0000, 1'b1);      // percent closing the string
        queue_beat(CH_X_LO, 16'h0000, 1'b0);     // must pass through as text
        queue_beat(CH_PCT, 16'h0000, 1'b0);
        queue_beat(CH_D_LO, 16'd10009, 1'b1);    // conversion on the last character
        drain();

        // Random strings under each idling pattern
        set_idling(0, 0);
        queue_random_run(15);
        drain();
        set_idling(69, 0);
        queue_random_run(15);
        drain();
        set_idling(0, 69);
        queue_random_run(15);
        drain();
        set_idling(7, 7);
        queue_random_run(15);
        drain();

        // Back-pressure: stop the sink for a long stretch while the sender
        // floods decimal and hex conversions, so the command queue fills
        set_idling(0, 0);
        hold_req++;
        repeat (12)
        begin
            queue_beat(CH_PCT, 16'h0000, 1'b0);
            queue_beat(($urandom_range(0, 1) != 0) ? CH_D_LO : CH_X_UP, pick_value(), 1'b0);
        end
        queue_beat(CH_A_UP, 16'h0000, 1'b1);
        drain();

        // Let any stray beat surface before judging
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (tx_expect_q.size() != 0)
        begin
            $display("%0d expected chars never arrived", tx_expect_q.size());
        end
        if (mismatch_cnt == 0 && tx_expect_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/mpf_pkg.sv
hdl/mpf_if.sv
hdl/mpf_front.sv
hdl/mpf_fifo.sv
hdl/mpf_back.sv
hdl/mini_printf_value_formatter.sv
bench/tb_top.sv
